FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, masked while reset is low.
`define STPIT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("stpit assertion failed");

// Property checked on every rising clock edge, reset included.
`define STPIT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("stpit assertion failed");

`endif

FILE: hw/rtl/stpit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stpit_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 32;

  localparam logic signed [15:0] SNR_MIN = -16'sd25600;
  localparam logic signed [15:0] SNR_MAX = 16'sd25600;
  localparam logic [16:0]        PER_ONE = 17'd65536;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    LC_EXACT  = 3'd0,
    LC_BELOW  = 3'd1,
    LC_ABOVE  = 3'd2,
    LC_INTERP = 3'd3,
    LC_CACHE  = 3'd4
  } lookup_case_t;

  // One table point as it is stored in memory.
  typedef struct packed {
    logic [15:0] key;
    logic [16:0] rate;
  } entry_t;

  // Dividend and divisor widths of the interpolation divide.
  localparam int DIV_NUM_W = 34;
  localparam int DIV_DEN_W = 17;

endpackage
`default_nettype wire

FILE: hw/rtl/stpit_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module stpit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/stpit_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring unsigned divider, one quotient bit per cycle.
module stpit_div #(
  parameter int NW = 34,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output      logic          done,
  output      logic [NW-1:0] quo
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   den_r, den_nxt;
  logic [NW-1:0]   quo_r, quo_nxt;
  logic [DW:0]     rem_sh;
  logic [DW+1:0]   diff;
  logic            ge;

  assign rem_sh = {rem_r, quo_r[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = ~diff[DW+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

FILE: hw/rtl/snr_to_per_interpolating_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// SNR to packet error rate table with linear interpolation. The block holds up to
// TABLE_DEPTH (SNR, PER) points sorted by SNR in a single-port-read, single-port-write
// memory and handles one item at a time. A lookup that hits the one-entry result cache
// goes straight to the finish state. Otherwise the table is scanned from the lowest key,
// each point passing through a read state and a compare state. An exact hit, a
// below-range or an above-range answer ends there. An interpolated answer adds a multiply
// state, a divider start state and a wait state in which the restoring divider works
// through 34 quotient bits and reports done. An insert scans the same way and then opens
// a slot by moving every higher point up one place, each through a shift-read and a
// shift-write state, and then writes the new point. Rejected inserts (out of range,
// duplicate key, full table) finish right after the check. Every insert transfer,
// accepted or rejected, empties the cache. The result register lets a new input transfer
// be taken while the previous result still waits.
module snr_to_per_interpolating_table_core #(
  parameter int TABLE_DEPTH = stpit_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_op,
  input  wire logic signed [15:0] in_snr_value,
  input  wire logic [16:0]        in_per_value,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [16:0]        out_per_result,
  output      logic [1:0]         out_status,
  output      logic [2:0]         out_lookup_case,
  output      logic [5:0]         out_point_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(stpit_pkg::entry_t);
  localparam int NW = stpit_pkg::DIV_NUM_W;
  localparam int DW = stpit_pkg::DIV_DEN_W;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_RD       = 11'b000_0000_0010,
    S_CMP      = 11'b000_0000_0100,
    S_EVAL     = 11'b000_0000_1000,
    S_SHIFT_RD = 11'b000_0001_0000,
    S_SHIFT_WR = 11'b000_0010_0000,
    S_PUT      = 11'b000_0100_0000,
    S_MUL      = 11'b000_1000_0000,
    S_DIV_GO   = 11'b001_0000_0000,
    S_DIV_WAIT = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Item being worked on.
  logic               op_r, op_nxt;
  logic [15:0]        key_r, key_nxt;
  logic [16:0]        rate_r, rate_nxt;

  // Table bookkeeping and scan position.
  logic [CW-1:0]      held_r, held_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [CW-1:0]      jm1;
  stpit_pkg::entry_t  lo_r, lo_nxt;
  stpit_pkg::entry_t  hi_r, hi_nxt;

  // Result cache.
  logic               cvalid_r, cvalid_nxt;
  logic [15:0]        ckey_r, ckey_nxt;
  logic [16:0]        crate_r, crate_nxt;

  // Result being built.
  logic [16:0]        res_per_r, res_per_nxt;
  stpit_pkg::status_t res_st_r, res_st_nxt;
  stpit_pkg::lookup_case_t res_lc_r, res_lc_nxt;

  // Interpolation datapath.
  logic signed [34:0] prod_r, prod_nxt;
  logic [DW-1:0]      den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic signed [16:0] dk;
  logic signed [16:0] dden;
  logic signed [17:0] dr;
  logic [34:0]        mag;
  logic               div_start;
  logic               div_done;
  logic [NW-1:0]      div_quo;
  logic signed [19:0] qs;
  logic signed [19:0] sum;

  // Output register.
  logic               ovalid_r, ovalid_nxt;
  logic [16:0]        oper_r, oper_nxt;
  logic [1:0]         ost_r, ost_nxt;
  logic [2:0]         olc_r, olc_nxt;
  logic [5:0]         ocnt_r, ocnt_nxt;
  logic [CW+5:0]      held_ext;

  // Memory port.
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [EW-1:0]      ram_wdata, ram_rdata;
  stpit_pkg::entry_t  rd_e;

  logic               accept;
  logic               range_bad;
  logic               found;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign range_bad = (in_snr_value < stpit_pkg::SNR_MIN) ||
                     (in_snr_value > stpit_pkg::SNR_MAX) ||
                     (in_per_value > stpit_pkg::PER_ONE);
  assign rd_e      = stpit_pkg::entry_t'(ram_rdata);
  assign jm1       = j_r - 1'b1;
  assign found     = (idx_r != held_r);

  assign dk   = $signed({key_r[15], key_r}) - $signed({lo_r.key[15], lo_r.key});
  assign dden = $signed({hi_r.key[15], hi_r.key}) - $signed({lo_r.key[15], lo_r.key});
  assign dr   = $signed({1'b0, hi_r.rate}) - $signed({1'b0, lo_r.rate});
  assign mag  = prod_r[34] ? 35'(-prod_r) : 35'(prod_r);
  assign qs   = neg_r ? -$signed({3'b000, div_quo[16:0]}) : $signed({3'b000, div_quo[16:0]});
  assign sum  = $signed({3'b000, lo_r.rate}) + qs;
  assign div_start = (state_r == S_DIV_GO);
  assign held_ext  = {6'b000000, held_r};

  // The memory sees at most one read and one write per cycle; the sequencer never
  // reads and writes the same entry in flight, so no forwarding is needed.
  assign ram_re    = (state_r == S_RD) || (state_r == S_SHIFT_RD);
  assign ram_raddr = (state_r == S_SHIFT_RD) ? jm1[AW-1:0] : idx_r[AW-1:0];
  assign ram_we    = (state_r == S_SHIFT_WR) || (state_r == S_PUT);
  assign ram_waddr = (state_r == S_PUT) ? idx_r[AW-1:0] : j_r[AW-1:0];
  assign ram_wdata = (state_r == S_PUT) ? {key_r, rate_r} : ram_rdata;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    rate_nxt    = rate_r;
    held_nxt    = held_r;
    idx_nxt     = idx_r;
    j_nxt       = j_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    cvalid_nxt  = cvalid_r;
    ckey_nxt    = ckey_r;
    crate_nxt   = crate_r;
    res_per_nxt = res_per_r;
    res_st_nxt  = res_st_r;
    res_lc_nxt  = res_lc_r;
    prod_nxt    = prod_r;
    den_nxt     = den_r;
    neg_nxt     = neg_r;
    ovalid_nxt  = ovalid_r;
    oper_nxt    = oper_r;
    ost_nxt     = ost_r;
    olc_nxt     = olc_r;
    ocnt_nxt    = ocnt_r;

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_op;
          key_nxt     = in_snr_value;
          rate_nxt    = in_per_value;
          idx_nxt     = '0;
          res_per_nxt = '0;
          res_st_nxt  = stpit_pkg::ST_OK;
          res_lc_nxt  = stpit_pkg::LC_EXACT;
          if (in_op == stpit_pkg::OP_INSERT) begin
            cvalid_nxt = 1'b0;
            if (range_bad) begin
              res_st_nxt = stpit_pkg::ST_RANGE;
              state_nxt  = S_FINISH;
            end else begin
              state_nxt = (held_r == '0) ? S_EVAL : S_RD;
            end
          end else if (cvalid_r && (ckey_r == in_snr_value)) begin
            res_per_nxt = crate_r;
            res_lc_nxt  = stpit_pkg::LC_CACHE;
            state_nxt   = S_FINISH;
          end else begin
            state_nxt = (held_r == '0) ? S_EVAL : S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if ($signed(rd_e.key) < $signed(key_r)) begin
          lo_nxt  = rd_e;
          idx_nxt = idx_r + 1'b1;
          state_nxt = (idx_r + 1'b1 == held_r) ? S_EVAL : S_RD;
        end else begin
          hi_nxt    = rd_e;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (op_r == stpit_pkg::OP_INSERT) begin
          if (found && (hi_r.key == key_r)) begin
            res_st_nxt = stpit_pkg::ST_DUP;
            state_nxt  = S_FINISH;
          end else if (held_r == CW'(TABLE_DEPTH)) begin
            res_st_nxt = stpit_pkg::ST_FULL;
            state_nxt  = S_FINISH;
          end else if (held_r == idx_r) begin
            state_nxt = S_PUT;
          end else begin
            j_nxt     = held_r;
            state_nxt = S_SHIFT_RD;
          end
        end else if (found && (hi_r.key == key_r)) begin
          res_per_nxt = hi_r.rate;
          res_lc_nxt  = stpit_pkg::LC_EXACT;
          state_nxt   = S_FINISH;
        end else if (idx_r == '0) begin
          res_per_nxt = stpit_pkg::PER_ONE;
          res_lc_nxt  = stpit_pkg::LC_BELOW;
          state_nxt   = S_FINISH;
        end else if (!found) begin
          res_per_nxt = '0;
          res_lc_nxt  = stpit_pkg::LC_ABOVE;
          state_nxt   = S_FINISH;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_SHIFT_RD: begin
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        j_nxt     = jm1;
        state_nxt = (jm1 == idx_r) ? S_PUT : S_SHIFT_RD;
      end
      S_PUT: begin
        held_nxt  = held_r + 1'b1;
        state_nxt = S_FINISH;
      end
      S_MUL: begin
        prod_nxt  = 35'(dk * dr);
        den_nxt   = dden[DW-1:0];
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        neg_nxt   = prod_r[34];
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (sum < 0) begin
            res_per_nxt = '0;
          end else if (sum > $signed({3'b000, stpit_pkg::PER_ONE})) begin
            res_per_nxt = stpit_pkg::PER_ONE;
          end else begin
            res_per_nxt = sum[16:0];
          end
          res_lc_nxt = stpit_pkg::LC_INTERP;
          state_nxt  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          oper_nxt   = res_per_r;
          ost_nxt    = res_st_r;
          olc_nxt    = res_lc_r;
          ocnt_nxt   = held_ext[5:0];
          if (op_r == stpit_pkg::OP_LOOKUP) begin
            cvalid_nxt = 1'b1;
            ckey_nxt   = key_r;
            crate_nxt  = res_per_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      held_r   <= '0;
      cvalid_r <= 1'b0;
      ckey_r   <= '0;
      crate_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      cvalid_r <= cvalid_nxt;
      ckey_r   <= ckey_nxt;
      crate_r  <= crate_nxt;
      ovalid_r <= ovalid_nxt;
    end
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    rate_r    <= rate_nxt;
    idx_r     <= idx_nxt;
    j_r       <= j_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    res_per_r <= res_per_nxt;
    res_st_r  <= res_st_nxt;
    res_lc_r  <= res_lc_nxt;
    prod_r    <= prod_nxt;
    den_r     <= den_nxt;
    neg_r     <= neg_nxt;
    oper_r    <= oper_nxt;
    ost_r     <= ost_nxt;
    olc_r     <= olc_nxt;
    ocnt_r    <= ocnt_nxt;
  end

  stpit_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stpit_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mag[NW-1:0]),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid       = ovalid_r;
  assign out_per_result  = oper_r;
  assign out_status      = ost_r;
  assign out_lookup_case = olc_r;
  assign out_point_count = ocnt_r;

endmodule
`default_nettype wire

FILE: hw/rtl/stpit_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module stpit_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_op,
  input wire logic signed [15:0] in_snr_value,
  input wire logic [16:0]        in_per_value,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [16:0]        out_per_result,
  input wire logic [1:0]         out_status,
  input wire logic [2:0]         out_lookup_case,
  input wire logic [5:0]         out_point_count
);

  // A result waiting for its transfer keeps its rate and its status.
  `STPIT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_per_result) && $stable(out_status))

  // A rejected or flagged insert carries a zero rate and lookup case LC_EXACT.
  `STPIT_ASSERT(a_status_clean, clk, rst_n, out_valid && (out_status != stpit_pkg::ST_OK) |-> (out_per_result == '0) && (out_lookup_case == stpit_pkg::LC_EXACT))

  // Rates never exceed one.
  `STPIT_ASSERT(a_per_range, clk, rst_n, out_valid |-> out_per_result <= stpit_pkg::PER_ONE)

  // One item at a time: an input transfer closes the input side.
  `STPIT_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready)

  // Reset leaves no result pending.
  `STPIT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind snr_to_per_interpolating_table_core stpit_checker u_stpit_checker (.*);
`default_nettype wire
